// File: rtl/core/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types and constants of the bitmap text renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

    // Operation codes carried in s_tuser
    localparam logic [1:0] OP_FONT_WRITE = 2'd0;
    localparam logic [1:0] OP_START      = 2'd1;
    localparam logic [1:0] OP_CHAR       = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH = 2'd0;
    localparam logic [1:0] CFG_TEXT_COLOR   = 2'd1;
    localparam logic [1:0] CFG_BG_COLOR     = 2'd2;

    localparam int          STORE_DEPTH  = 768;
    localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
    localparam logic [9:0]  ROW_MAX      = 10'd1023;
    localparam logic [12:0] COL_MAX      = 13'd4095;
    localparam logic [10:0] WIDTH_RESET  = 11'd320;
    localparam logic [2:0]  GLYPH_MSB    = 3'd7;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_DATA_W = 11;

    // Datapath to controller
    typedef struct packed {
        logic draw_req;
        logic visible;
        logic out_free;
        logic col_last;
        logic row_last;
    } dp_status_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic advance;
        logic emit;
    } dp_cmd_t;

endpackage

// File: rtl/core/btr_ctrl.sv
// ----------------------------------------------------------------------------
// btr_ctrl
// Sequencer: takes one item at a time and walks a glyph pixel by pixel.
// ----------------------------------------------------------------------------
module btr_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  btr_pkg::dp_status_t status,
    output btr_pkg::dp_cmd_t    cmd
);
    import btr_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && status.draw_req) begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW: begin
                // hidden columns step freely, visible ones wait for a free slot
                cmd.emit    = status.visible && status.out_free;
                cmd.advance = !status.visible || status.out_free;
                if (cmd.advance && status.col_last && status.row_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/btr_datapath.sv
// ----------------------------------------------------------------------------
// btr_datapath
// Font store, cursor, configuration registers, address generation and
// output register of the bitmap text renderer.
// ----------------------------------------------------------------------------
module btr_datapath #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 6,
    parameter int FONT_CHARS   = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  btr_pkg::dp_cmd_t                  cmd,
    output btr_pkg::dp_status_t               status,
    input  logic [btr_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic [1:0]                        s_tuser,
    input  logic                              cfg_valid,
    input  logic [1:0]                        cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [btr_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import btr_pkg::*;

    localparam int JW = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;
    localparam int IW = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

    // input fields
    logic [1:0]  in_op;
    logic [7:0]  in_char;
    logic [10:0] in_start_x;
    logic [9:0]  in_start_y;
    logic [9:0]  in_font_addr;
    logic [7:0]  in_font_byte;

    assign in_op        = s_tuser;
    assign in_char      = s_tdata[7:0];
    assign in_start_x   = s_tdata[18:8];
    assign in_start_y   = s_tdata[28:19];
    assign in_font_addr = s_tdata[38:29];
    assign in_font_byte = s_tdata[46:39];

    logic [7:0] font_mem [STORE_DEPTH];

    logic [10:0]   width_reg;
    logic [7:0]    text_color_reg;
    logic [7:0]    bg_color_reg;
    logic [12:0]   cursor_col_reg;
    logic [9:0]    cursor_row_reg;
    logic [10:0]   origin_col_reg;

    logic [12:0]   draw_col_reg;
    logic [21:0]   row_base_reg;
    logic [11:0]   font_base_reg;
    logic [JW-1:0] col_idx_reg;
    logic [IW-1:0] row_idx_reg;
    logic [JW-1:0] jlast_reg;
    logic [7:0]    font_q_reg;

    logic          m_tvalid_reg;
    logic [19:0]   addr_out_reg;
    logic [7:0]    pix_out_reg;
    logic          off_out_reg;
    logic          last_out_reg;

    logic          is_char;
    logic          is_newline;
    logic          draw_req;
    logic [11:0]   font_base_in;
    logic [11:0]   rd_addr;
    logic          rd_en;
    logic [13:0]   px;
    logic          visible;
    logic          col_last;
    logic          row_last;
    logic [20:0]   row_prod;
    logic [21:0]   full_addr;
    logic [2:0]    bit_idx;
    logic [10:0]   row_sum;
    logic [13:0]   col_sum;
    logic [12:0]   col_adv;
    logic [9:0]    row_adv;
    logic [JW-1:0] jlast_next;

    assign is_char    = (in_op == OP_CHAR);
    assign is_newline = is_char && (in_char == NEWLINE_CODE);
    assign draw_req   = is_char && !is_newline && ({1'b0, in_char} < 9'(FONT_CHARS));

    assign font_base_in = 12'(in_char) * 12'(GLYPH_HEIGHT);
    assign rd_addr = cmd.accept ? font_base_in
                                : font_base_reg + 12'(row_idx_reg) + 12'd1;
    assign col_last = (col_idx_reg == JW'(GLYPH_WIDTH - 1));
    assign row_last = (row_idx_reg == IW'(GLYPH_HEIGHT - 1));
    assign rd_en    = (cmd.accept && draw_req) || (cmd.advance && col_last && !row_last);

    // pixel column under the walk
    assign px      = {draw_col_reg[12], draw_col_reg} + {{(14-JW){1'b0}}, col_idx_reg};
    assign visible = !px[13] && (px < {3'b000, width_reg});

    assign row_prod  = 21'(cursor_row_reg) * 21'(width_reg);
    assign full_addr = row_base_reg + {11'b0, px[10:0]};
    assign bit_idx   = GLYPH_MSB - 3'(col_idx_reg);

    assign row_sum = {1'b0, cursor_row_reg} + 11'(GLYPH_HEIGHT);
    assign row_adv = (row_sum > {1'b0, ROW_MAX}) ? ROW_MAX : row_sum[9:0];
    assign col_sum = {cursor_col_reg[12], cursor_col_reg} + 14'(GLYPH_WIDTH);
    assign col_adv = (!col_sum[13] && col_sum[12]) ? COL_MAX : col_sum[12:0];

    // rightmost visible column of the glyph at the current cursor
    always_comb begin
        logic [13:0] pk;
        jlast_next = '0;
        for (int k = 0; k < GLYPH_WIDTH; k++) begin
            pk = {cursor_col_reg[12], cursor_col_reg} + 14'(k);
            if (!pk[13] && (pk < {3'b000, width_reg})) begin
                jlast_next = JW'(k);
            end
        end
    end

    always_comb begin
        status          = '0;
        status.draw_req = draw_req;
        status.visible  = visible;
        status.out_free = !m_tvalid_reg || m_tready;
        status.col_last = col_last;
        status.row_last = row_last;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= WIDTH_RESET;
            text_color_reg <= '0;
            bg_color_reg   <= '0;
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
            origin_col_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH: width_reg      <= cfg_data;
                    CFG_TEXT_COLOR:   text_color_reg <= cfg_data[7:0];
                    CFG_BG_COLOR:     bg_color_reg   <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.accept) begin
                case (in_op)
                    OP_START: begin
                        origin_col_reg <= in_start_x;
                        cursor_col_reg <= {{2{in_start_x[10]}}, in_start_x};
                        cursor_row_reg <= in_start_y;
                    end
                    OP_CHAR: begin
                        if (is_newline) begin
                            cursor_col_reg <= {{2{origin_col_reg[10]}}, origin_col_reg};
                            cursor_row_reg <= row_adv;
                        end else begin
                            cursor_col_reg <= col_adv;
                        end
                    end
                    default: ;
                endcase
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // font store, walk registers and output payload
    always_ff @(posedge aclk) begin
        if (cmd.accept && (in_op == OP_FONT_WRITE)
                && ({2'b00, in_font_addr} < 12'(STORE_DEPTH))) begin
            font_mem[in_font_addr] <= in_font_byte;
        end
        if (rd_en) begin
            if (rd_addr < 12'(STORE_DEPTH)) begin
                font_q_reg <= font_mem[rd_addr[9:0]];
            end else begin
                font_q_reg <= '0;
            end
        end
        if (cmd.accept && draw_req) begin
            draw_col_reg  <= cursor_col_reg;
            row_base_reg  <= {1'b0, row_prod};
            font_base_reg <= font_base_in;
            jlast_reg     <= jlast_next;
            col_idx_reg   <= '0;
            row_idx_reg   <= '0;
        end else if (cmd.advance) begin
            if (col_last) begin
                col_idx_reg  <= '0;
                row_idx_reg  <= row_idx_reg + IW'(1);
                row_base_reg <= row_base_reg + {11'b0, width_reg};
            end else begin
                col_idx_reg <= col_idx_reg + JW'(1);
            end
        end
        if (cmd.emit) begin
            addr_out_reg <= full_addr[19:0];
            pix_out_reg  <= font_q_reg[bit_idx] ? text_color_reg : bg_color_reg;
            off_out_reg  <= |full_addr[21:20];
            last_out_reg <= row_last && (col_idx_reg == jlast_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, off_out_reg & 1'b0, pix_out_reg, addr_out_reg};
    assign m_tuser  = off_out_reg;
    assign m_tlast  = last_out_reg;

endmodule

// File: rtl/core/bitmap_text_renderer_top.sv
// ----------------------------------------------------------------------------
// bitmap_text_renderer_top
// Character-cell text renderer producing pixel writes for an 8-bit frame.
// ----------------------------------------------------------------------------
// Input stream (s_*): s_tuser carries the operation (0 font byte write,
// 1 start string, 2 character). Font writes, string starts, newlines and codes
// beyond the font give no output. A drawn character walks its glyph through
// GLYPH_WIDTH * GLYPH_HEIGHT column positions (48 by default), one position
// per cycle unless the receiver stalls, and the next item is accepted after
// that walk. The first font row is read at acceptance; later rows are fetched
// as the walk wraps. Output stream (m_*): one transfer per visible pixel,
// m_tlast on the final one of a character; results leave from the output register.
// A stalled receiver holds the walk on visible pixels only; hidden columns
// keep stepping. The output register lets the next item be taken while the
// last pixel still waits.
// Configuration (cfg_*): always ready; write only while the block is idle.
// Reset: cursor and origin go to zero, screen width to 320, colors to zero;
// the font store is not cleared.
// ----------------------------------------------------------------------------
module bitmap_text_renderer_top #(
    parameter int GLYPH_WIDTH  = 8,
    parameter int GLYPH_HEIGHT = 6,
    parameter int FONT_CHARS   = 128
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: character[7:0], start_x[18:8], start_y[28:19],
    //          font_address[38:29], font_byte[46:39], zero pad[47]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [btr_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: operation[1:0]
    input  logic [1:0]                      s_tuser,
    // m_tdata: fb_address[19:0], pixel_value[27:20], zero pad[31:28]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [btr_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser: off_frame[0]
    output logic                            m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [btr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import btr_pkg::*;

    dp_status_t status;
    dp_cmd_t    cmd;

    assign cfg_ready = 1'b1;

    btr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    btr_datapath #(
        .GLYPH_WIDTH  (GLYPH_WIDTH),
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .FONT_CHARS   (FONT_CHARS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
